>>> hdl/bounded_stack_with_search_defines.svh
// Assertion macros for the stack with search
`ifndef BOUNDED_STACK_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_STACK_WITH_SEARCH_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define BSWS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BSWS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/bsws_pkg.sv
package bsws_pkg;

   localparam int VALUE_W     = 32;
   localparam int CAP_W       = 7;
   localparam int POS_W       = 6;
   localparam int OUT_COUNT_W = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [1:0] {
      REQ_PUSH   = 2'd0,
      REQ_POP    = 2'd1,
      REQ_SEARCH = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_kind_type;

   // register index, taken from paddr[2]
   localparam logic REG_CAPACITY = 1'b0;

   typedef struct packed {
      logic push;   // write the cell sitting at the current count
      logic load;   // capture compare result against the key
      logic shift;  // take the match bit from the upper neighbour
   } cell_ctl_type;

endpackage

>>> hdl/bsws_cell.sv
module bsws_cell
   import bsws_pkg::*;
#(
   parameter int CW  = 7,
   parameter int IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  cell_ctl_type        ctl,
   input  logic [CW-1:0]       count,
   input  logic [VALUE_W-1:0]  data,
   input  logic                upper_match,
   output logic                match_out
);

   localparam logic [CW-1:0] MY_POS = CW'(IDX);

   logic [VALUE_W-1:0] value_ff;
   logic               match_ff;
   logic               match_in;

   always_comb begin
      match_in = match_ff;
      if (ctl.load) begin
         match_in = (MY_POS < count) && (value_ff == data);
      end else if (ctl.shift) begin
         match_in = upper_match;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push && (count == MY_POS)) begin
         value_ff <= data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign match_out = match_ff;

endmodule

>>> hdl/bounded_stack_with_search.sv
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tuser: req_type; tdata: value
// rsp     | out | rsp_tvalid/rsp_tready | tuser: success; tdata: found_position, item_count
// csr     | in  | APB, pready tied high | capacity at byte address 0
// Push, pop and clear: result registered in the cycle after the item is taken.
// Search: the cells compare in the cycle the item is taken, then the match bits move
// one cell per cycle towards the bottom until a hit reaches cell 0 or all items
// are passed; an empty stack gets no scan. One item in flight; req_tready waits for the
// scan and a free output register. Synchronous active-high reset: empty stack, capacity 64.
`include "bounded_stack_with_search_defines.svh"

module bounded_stack_with_search
   import bsws_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_tuser,   // [1:0] req_type
   input  logic [31:0]         req_tdata,   // [31:0] value
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic                rsp_tuser,   // [0] success
   output logic [15:0]         rsp_tdata,   // [5:0] found_position, [12:6] item_count, [15:13] 0
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = (CW > CAP_W) ? CW : CAP_W;
   localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          scan_ff, scan_in;
   logic [CAP_W-1:0]       cap_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff, rsp_ok_in;
   logic [POS_W-1:0]       rsp_pos_ff, rsp_pos_in;
   logic [OUT_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                   req_accept;
   logic                   csr_write;
   logic [EW-1:0]          cap_e, eff_cap;
   logic                   push_ok;
   logic [DEPTH-1:0]       match;
   cell_ctl_type           ctl;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_CAPACITY);
   assign csr_prdata = (csr_paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_write) begin
         cap_ff <= csr_pwdata[CAP_W-1:0];
      end
   end

   assign cap_e   = EW'(cap_ff);
   assign eff_cap = (cap_e > DEPTH_E) ? DEPTH_E : cap_e;
   assign push_ok = EW'(count_ff) < eff_cap;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   assign ctl.push  = req_accept && (req_kind_type'(req_tuser) == REQ_PUSH) && push_ok;
   assign ctl.load  = req_accept && (req_kind_type'(req_tuser) == REQ_SEARCH)
                      && (count_ff != '0);
   assign ctl.shift = (state_ff == ST_SCAN);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic upper;
      if (i == DEPTH - 1) begin : g_top
         assign upper = 1'b0;
      end else begin : g_mid
         assign upper = match[i+1];
      end
      bsws_cell #(
         .CW  (CW),
         .IDX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .count       (count_ff),
         .data        (req_tdata),
         .upper_match (upper),
         .match_out   (match[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_count_in = rsp_count_ff;
      if (req_accept) begin
         case (req_kind_type'(req_tuser))
            REQ_PUSH: begin
               if (push_ok) begin
                  count_in = CW'(count_ff + 1'b1);
               end
               rsp_valid_in = 1'b1;
               rsp_ok_in    = push_ok;
               rsp_pos_in   = '0;
               rsp_count_in = OUT_COUNT_W'(count_in);
            end
            REQ_POP: begin
               if (count_ff != '0) begin
                  count_in = CW'(count_ff - 1'b1);
               end
               rsp_valid_in = 1'b1;
               rsp_ok_in    = (count_ff != '0);
               rsp_pos_in   = '0;
               rsp_count_in = OUT_COUNT_W'(count_in);
            end
            REQ_SEARCH: begin
               if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b0;
                  rsp_pos_in   = '0;
                  rsp_count_in = OUT_COUNT_W'(count_ff);
               end else begin
                  state_in = ST_SCAN;
                  scan_in  = '0;
               end
            end
            REQ_CLEAR: begin
               count_in     = '0;
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_pos_in   = '0;
               rsp_count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
      if (state_ff == ST_SCAN) begin
         if (match[0]) begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_pos_in   = POS_W'(scan_ff);
            rsp_count_in = OUT_COUNT_W'(count_ff);
         end else if (CW'(scan_ff + 1'b1) == count_ff) begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b0;
            rsp_pos_in   = '0;
            rsp_count_in = OUT_COUNT_W'(count_ff);
         end else begin
            scan_in = CW'(scan_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff      <= scan_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_pos_ff};

   `BSWS_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= DEPTH_C, "entry count above depth")
   `BSWS_ASSERT_NOW(a_busy_stall, state_ff == ST_SCAN, !req_tready && !rsp_valid_ff,
                    "item taken or result pending during scan")
   `BSWS_ASSERT_NEXT(a_clear, req_accept && (req_tuser == REQ_CLEAR),
                     count_ff == '0 && rsp_valid_ff, "clear did not empty the stack")
   `BSWS_ASSERT_NEXT(a_push, ctl.push, count_ff == CW'($past(count_ff) + 1'b1),
                     "push did not advance the count")

endmodule
